>>> src/rafbu_pkg.sv
// Package of shared types and constants for the register, ALU, flags and branch unit.
`timescale 1ns / 1ps
`default_nettype none

package rafbu_pkg;

    // Default data path width and register count.
    localparam int WORD_BITS_DEF = 64;
    localparam int REG_COUNT     = 8;
    localparam int REG_IDX_BITS  = $clog2(REG_COUNT);

    // Operation codes.
    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_CMP    = 4'd2,
        OP_MOVE   = 4'd3,
        OP_AND    = 4'd4,
        OP_OR     = 4'd5,
        OP_XOR    = 4'd6,
        OP_SHL    = 4'd7,
        OP_SHR    = 4'd8,
        OP_ASR    = 4'd9,
        OP_BRANCH = 4'd10
    } op_t;

    // Branch condition codes.
    typedef enum logic [2:0] {
        CC_EQ       = 3'd0,
        CC_NE       = 3'd1,
        CC_GT       = 3'd2,
        CC_LT       = 3'd3,
        CC_ABOVE    = 3'd4,
        CC_NO_CARRY = 3'd5,
        CC_CARRY    = 3'd6,
        CC_OVERFLOW = 3'd7
    } cond_t;

    // Condition flags.
    typedef struct packed {
        logic zero;
        logic negative;
        logic carry;
        logic overflow;
    } flags_t;

    // Decoded instruction word.
    typedef struct packed {
        logic [3:0]  operation;
        logic [2:0]  dest_reg;
        logic [2:0]  src_a_reg;
        logic [2:0]  src_b_reg;
        logic        use_immediate;
        logic [63:0] immediate;
        logic [5:0]  shift_amount;
        logic [2:0]  cond_code;
    } rafbu_in_t;

    // Result word.
    typedef struct packed {
        logic [63:0] result;
        logic        flag_zero;
        logic        flag_negative;
        logic        flag_carry;
        logic        flag_overflow;
        logic        branch_taken;
    } rafbu_out_t;

endpackage

`default_nettype wire

>>> src/rafbu_regfile.sv
// Register file with one write port and two read ports with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rafbu_regfile #(
    parameter int WORD_BITS = rafbu_pkg::WORD_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             wr_en,
    input  wire logic [rafbu_pkg::REG_IDX_BITS-1:0] wr_addr,
    input  wire logic [WORD_BITS-1:0]             wr_data,
    input  wire logic                             rd_en,
    input  wire logic [rafbu_pkg::REG_IDX_BITS-1:0] rd_addr_a,
    input  wire logic [rafbu_pkg::REG_IDX_BITS-1:0] rd_addr_b,
    output logic      [WORD_BITS-1:0]             rd_data_a,
    output logic      [WORD_BITS-1:0]             rd_data_b
);
    import rafbu_pkg::*;

    logic [WORD_BITS-1:0] mem_reg [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [WORD_BITS-1:0] rd_a_reg;
    logic [WORD_BITS-1:0] rd_b_reg;
    logic                 rd_a_valid_reg;
    logic                 rd_b_valid_reg;

    // Storage and registered reads; the data itself needs no reset.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= mem_reg[rd_addr_a];
            rd_b_reg <= mem_reg[rd_addr_b];
        end
    end

    // Valid bits: an entry never written since reset reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            rd_a_valid_reg <= 1'b0;
            rd_b_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_a_valid_reg <= valid_reg[rd_addr_a];
                rd_b_valid_reg <= valid_reg[rd_addr_b];
            end
        end
    end

    assign rd_data_a = rd_a_valid_reg ? rd_a_reg : '0;
    assign rd_data_b = rd_b_valid_reg ? rd_b_reg : '0;

endmodule

`default_nettype wire

>>> src/rafbu_alu.sv
// Arithmetic, logic, shift and condition evaluation for one instruction.
`timescale 1ns / 1ps
`default_nettype none

module rafbu_alu #(
    parameter int WORD_BITS = rafbu_pkg::WORD_BITS_DEF
) (
    input  wire logic [3:0]            operation,
    input  wire logic [5:0]            shift_amount,
    input  wire logic [2:0]            cond_code,
    input  wire logic [WORD_BITS-1:0]  opnd_a,
    input  wire logic [WORD_BITS-1:0]  opnd_b,
    input  wire rafbu_pkg::flags_t     flags_in,
    output logic      [WORD_BITS-1:0]  result,
    output rafbu_pkg::flags_t          flags_out,
    output logic                       branch_taken,
    output logic                       wr_en
);
    import rafbu_pkg::*;

    localparam int MSB = WORD_BITS - 1;

    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS-1:0] diff;
    logic [WORD_BITS:0]   shl_ext;
    logic [WORD_BITS:0]   shr_ext;
    logic [WORD_BITS:0]   asr_ext;
    logic                 set_zn;

    // Shared adder, subtractor and shifters; the extra bit carries out the last bit shifted.
    always_comb begin
        sum     = {1'b0, opnd_a} + {1'b0, opnd_b};
        diff    = opnd_a - opnd_b;
        shl_ext = {1'b0, opnd_a} << shift_amount;
        shr_ext = {opnd_a, 1'b0} >> shift_amount;
        asr_ext = $unsigned($signed({opnd_a, 1'b0}) >>> shift_amount);
    end

    // Operation select and flag update.
    always_comb begin
        result       = '0;
        flags_out    = flags_in;
        branch_taken = 1'b0;
        wr_en        = 1'b0;
        set_zn       = 1'b0;
        case (operation)
            OP_ADD: begin
                result             = sum[WORD_BITS-1:0];
                flags_out.carry    = sum[WORD_BITS];
                flags_out.overflow = (opnd_a[MSB] == opnd_b[MSB]) &&
                                     (sum[MSB] != opnd_a[MSB]);
                set_zn             = 1'b1;
                wr_en              = 1'b1;
            end
            OP_SUB, OP_CMP: begin
                result             = diff;
                flags_out.carry    = opnd_a < opnd_b;
                flags_out.overflow = (opnd_a[MSB] != opnd_b[MSB]) &&
                                     (diff[MSB] != opnd_a[MSB]);
                set_zn             = 1'b1;
                wr_en              = (operation == OP_SUB);
            end
            OP_MOVE: begin
                result = opnd_b;
                wr_en  = 1'b1;
            end
            OP_AND, OP_OR, OP_XOR: begin
                if (operation == OP_AND) begin
                    result = opnd_a & opnd_b;
                end else if (operation == OP_OR) begin
                    result = opnd_a | opnd_b;
                end else begin
                    result = opnd_a ^ opnd_b;
                end
                flags_out.carry    = 1'b0;
                flags_out.overflow = 1'b0;
                set_zn             = 1'b1;
                wr_en              = 1'b1;
            end
            OP_SHL: begin
                result             = shl_ext[WORD_BITS-1:0];
                flags_out.carry    = shl_ext[WORD_BITS];
                flags_out.overflow = 1'b0;
                set_zn             = 1'b1;
                wr_en              = 1'b1;
            end
            OP_SHR: begin
                result             = shr_ext[WORD_BITS:1];
                flags_out.carry    = shr_ext[0];
                flags_out.overflow = 1'b0;
                set_zn             = 1'b1;
                wr_en              = 1'b1;
            end
            OP_ASR: begin
                result             = asr_ext[WORD_BITS:1];
                flags_out.carry    = asr_ext[0];
                flags_out.overflow = 1'b0;
                set_zn             = 1'b1;
                wr_en              = 1'b1;
            end
            OP_BRANCH: begin
                case (cond_code)
                    CC_EQ:       branch_taken = flags_in.zero;
                    CC_NE:       branch_taken = !flags_in.zero;
                    CC_GT:       branch_taken = (flags_in.negative == flags_in.overflow) &&
                                                !flags_in.zero;
                    CC_LT:       branch_taken = flags_in.negative != flags_in.overflow;
                    CC_ABOVE:    branch_taken = !(flags_in.zero || flags_in.carry);
                    CC_NO_CARRY: branch_taken = !flags_in.carry;
                    CC_CARRY:    branch_taken = flags_in.carry;
                    default:     branch_taken = flags_in.overflow;
                endcase
            end
            default: begin
                result = '0;
            end
        endcase
        if (set_zn) begin
            flags_out.zero     = (result == '0);
            flags_out.negative = result[MSB];
        end
    end

endmodule

`default_nettype wire

>>> src/register_alu_flags_branch_unit.sv
// Top level of the register, ALU, flags and branch execute unit.
//
// One decoded instruction word enters on the s_ channel (valid/ready) and one
// result word leaves on the m_ channel (valid/ready) for every instruction.
// An accepted word is held in an input register while the register file read
// completes; when the word moves on, the ALU computes, the register file and
// flags are updated and the result word is loaded into the output register.
// m_valid rises when the output register is loaded from the input register.
// Throughput is one word per cycle while the receiver keeps m_ready high: the
// input register is refilled in the same cycle that its word moves on, and a
// register written by one instruction is forwarded to the next.
// When the receiver stalls, the output register holds its word and the input
// register holds one more; s_ready then falls until m_ready returns.
// Reset clears the flags, marks every register as zero and empties both the
// input and output registers.
`timescale 1ns / 1ps
`default_nettype none

module register_alu_flags_branch_unit #(
    parameter int WORD_BITS = rafbu_pkg::WORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire rafbu_pkg::rafbu_in_t  s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output rafbu_pkg::rafbu_out_t      m_data
);
    import rafbu_pkg::*;

    rafbu_in_t            in_reg;
    logic                 in_valid_reg;
    logic                 in_valid_next;
    rafbu_out_t           out_reg;
    rafbu_out_t           out_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    flags_t               flags_reg;
    logic                 fwd_a_reg;
    logic                 fwd_b_reg;
    logic                 fwd_a_next;
    logic                 fwd_b_next;
    logic [WORD_BITS-1:0] fwd_val_reg;

    logic                 accept;
    logic                 advance;
    logic [WORD_BITS-1:0] rf_rd_a;
    logic [WORD_BITS-1:0] rf_rd_b;
    logic [WORD_BITS-1:0] opnd_a;
    logic [WORD_BITS-1:0] opnd_b;
    logic [WORD_BITS-1:0] alu_result;
    flags_t               alu_flags;
    logic                 alu_taken;
    logic                 alu_wr;
    logic                 rf_wr;

    // Handshake: the held word moves on when the output register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign rf_wr   = advance && alu_wr;

    // Register file, read as a word is accepted.
    rafbu_regfile #(
        .WORD_BITS (WORD_BITS)
    ) u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (rf_wr),
        .wr_addr   (in_reg.dest_reg),
        .wr_data   (alu_result),
        .rd_en     (accept),
        .rd_addr_a (s_data.src_a_reg),
        .rd_addr_b (s_data.src_b_reg),
        .rd_data_a (rf_rd_a),
        .rd_data_b (rf_rd_b)
    );

    // Operands, with the result of the previous instruction forwarded where it is newer.
    always_comb begin
        opnd_a = fwd_a_reg ? fwd_val_reg : rf_rd_a;
        if (in_reg.use_immediate) begin
            opnd_b = in_reg.immediate[WORD_BITS-1:0];
        end else begin
            opnd_b = fwd_b_reg ? fwd_val_reg : rf_rd_b;
        end
    end

    rafbu_alu #(
        .WORD_BITS (WORD_BITS)
    ) u_alu (
        .operation    (in_reg.operation),
        .shift_amount (in_reg.shift_amount),
        .cond_code    (in_reg.cond_code),
        .opnd_a       (opnd_a),
        .opnd_b       (opnd_b),
        .flags_in     (flags_reg),
        .result       (alu_result),
        .flags_out    (alu_flags),
        .branch_taken (alu_taken),
        .wr_en        (alu_wr)
    );

    // Next-state logic for the pipeline control and the result word.
    always_comb begin
        in_valid_next  = accept || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_ready);
        fwd_a_next     = rf_wr && (in_reg.dest_reg == s_data.src_a_reg);
        fwd_b_next     = rf_wr && (in_reg.dest_reg == s_data.src_b_reg);
        out_next.result        = 64'(alu_result);
        out_next.flag_zero     = alu_flags.zero;
        out_next.flag_negative = alu_flags.negative;
        out_next.flag_carry    = alu_flags.carry;
        out_next.flag_overflow = alu_flags.overflow;
        out_next.branch_taken  = alu_taken;
    end

    // Control state and flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            fwd_a_reg     <= 1'b0;
            fwd_b_reg     <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                flags_reg <= alu_flags;
            end
            if (accept) begin
                fwd_a_reg <= fwd_a_next;
                fwd_b_reg <= fwd_b_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg      <= s_data;
            fwd_val_reg <= alu_result;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire
